[hw/rtl/bfra_pkg.sv]
// Shared types, codes and defaults for the best-fit region allocator.
package bfra_pkg;

    localparam int FREE_ENTRIES_DEF   = 64;
    localparam int ACTIVE_ENTRIES_DEF = 64;
    localparam int ADDR_BITS_DEF      = 48;

    localparam int LEN_W   = 32;
    localparam int TYPE_W  = 8;
    localparam int FADDR_W = 48;

    typedef enum logic [1:0] {
        MODE_ADD,
        MODE_ALLOC,
        MODE_RELEASE,
        MODE_SHRINK
    } bfra_mode_t;

    typedef enum logic [2:0] {
        STAT_OK,
        STAT_NO_FIT,
        STAT_NOT_ALLOC,
        STAT_TOO_LARGE,
        STAT_FULL
    } bfra_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_FSCAN,
        ST_ASCAN,
        ST_APPLY,
        ST_LAST_RD,
        ST_LAST_MV,
        ST_SORT_RD,
        ST_SORT_KEY,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_MRG_START,
        ST_MRG_LOAD,
        ST_MRG_STEP,
        ST_MRG_TAIL,
        ST_DONE
    } bfra_state_t;

    typedef struct packed {
        bfra_mode_t          mode;
        logic [LEN_W-1:0]    size;
        logic [FADDR_W-1:0]  addr;
        logic [FADDR_W-1:0]  lo;
        logic [FADDR_W-1:0]  hi;
        logic [TYPE_W-1:0]   type_bits;
    } bfra_req_t;

    typedef struct packed {
        bfra_status_t        status;
        logic [FADDR_W-1:0]  result_addr;
        logic [FADDR_W-1:0]  free_total;
        logic [FADDR_W-1:0]  freed_total;
    } bfra_rsp_t;

endpackage

[hw/rtl/best_fit_region_allocator.sv]
// Top level of the best-fit region allocator: sequencer, free and active tables.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------
//  s_      | in  | s_valid / s_ready   | s_req (mode, size, addr, lo, hi, type)
//  m_      | out | m_valid / m_ready   | m_rsp (status, addr, free/freed totals)
//
// One request at a time. Add writes one free entry. Allocate scans the free
// table and, if a region fits, the active table; on an exact fit it also moves
// the last free entry into the hole. Release and shrink scan the active table.
// A shrink that frees space adds an insertion sort and a merge pass over the
// free table. Each table has a single read port.
// Reset (aresetn low, synchronous) clears counts, totals and active valid
// bits; table contents need no clearing. A result waiting in the output
// register does not block the next request; a finished request holds in
// ST_DONE only while that register is still occupied.
module best_fit_region_allocator #(
    parameter int FREE_ENTRIES   = bfra_pkg::FREE_ENTRIES_DEF,
    parameter int ACTIVE_ENTRIES = bfra_pkg::ACTIVE_ENTRIES_DEF,
    parameter int ADDR_BITS      = bfra_pkg::ADDR_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bfra_pkg::bfra_req_t s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output bfra_pkg::bfra_rsp_t m_rsp
);

    import bfra_pkg::*;

    localparam int FIDX = $clog2(FREE_ENTRIES);
    localparam int FCNT = $clog2(FREE_ENTRIES + 1);
    localparam int AIDX = $clog2(ACTIVE_ENTRIES);
    localparam int ACNT = $clog2(ACTIVE_ENTRIES + 1);
    localparam int SW   = (FCNT > ACNT) ? FCNT : ACNT;
    localparam int CW   = (ADDR_BITS > FADDR_W) ? ADDR_BITS : FADDR_W;
    localparam int DW   = (ADDR_BITS > LEN_W + 1) ? ADDR_BITS : LEN_W + 1;
    localparam int EW   = ADDR_BITS + LEN_W + TYPE_W;

    // Control state
    bfra_state_t                state_reg, state_next;
    bfra_req_t                  req_reg, req_next;
    logic [FCNT-1:0]            free_count_reg, free_count_next;
    logic [FADDR_W-1:0]         free_bytes_reg, free_bytes_next;
    logic [FADDR_W-1:0]         freed_bytes_reg, freed_bytes_next;
    logic [ACTIVE_ENTRIES-1:0]  act_valid_reg, act_valid_next;
    logic [SW-1:0]              scan_idx_reg, scan_idx_next;
    logic                       chk_vld_reg, chk_vld_next;
    logic [SW-1:0]              chk_idx_reg, chk_idx_next;
    logic                       m_valid_reg, m_valid_next;

    // Scan results
    logic                       best_vld_reg, best_vld_next;
    logic [FIDX-1:0]            best_idx_reg, best_idx_next;
    logic [ADDR_BITS-1:0]       best_base_reg, best_base_next;
    logic [LEN_W-1:0]           best_len_reg, best_len_next;
    logic [TYPE_W-1:0]          best_type_reg, best_type_next;
    logic                       hit_reg, hit_next;
    logic [AIDX-1:0]            hit_idx_reg, hit_idx_next;
    logic [LEN_W-1:0]           hit_len_reg, hit_len_next;
    logic [TYPE_W-1:0]          hit_type_reg, hit_type_next;
    logic                       vac_vld_reg, vac_vld_next;
    logic [AIDX-1:0]            vac_idx_reg, vac_idx_next;

    // Result and compaction working registers
    bfra_status_t               status_reg, status_next;
    logic [FADDR_W-1:0]         res_reg, res_next;
    logic [FCNT-1:0]            sort_i_reg, sort_i_next;
    logic [FCNT-1:0]            sort_j_reg, sort_j_next;
    logic [EW-1:0]              key_reg, key_next;
    logic [EW-1:0]              pend_reg, pend_next;
    logic [FCNT-1:0]            m_idx_reg, m_idx_next;
    logic [FCNT-1:0]            n_reg, n_next;
    bfra_rsp_t                  m_rsp_reg, m_rsp_next;

    // Table ports
    logic                       fr_we;
    logic [FIDX-1:0]            fr_waddr, fr_raddr;
    logic [EW-1:0]              fr_wdata, fr_rdata;
    logic                       ac_we;
    logic [AIDX-1:0]            ac_waddr, ac_raddr;
    logic [EW-1:0]              ac_wdata, ac_rdata;

    bfra_ram #(
        .DEPTH (FREE_ENTRIES),
        .WIDTH (EW),
        .AW    (FIDX)
    ) u_free_tbl (
        .aclk    (aclk),
        .wr_en   (fr_we),
        .wr_addr (fr_waddr),
        .wr_data (fr_wdata),
        .rd_addr (fr_raddr),
        .rd_data (fr_rdata)
    );

    bfra_ram #(
        .DEPTH (ACTIVE_ENTRIES),
        .WIDTH (EW),
        .AW    (AIDX)
    ) u_active_tbl (
        .aclk    (aclk),
        .wr_en   (ac_we),
        .wr_addr (ac_waddr),
        .wr_data (ac_wdata),
        .rd_addr (ac_raddr),
        .rd_data (ac_rdata)
    );

    // Entry field views
    logic [ADDR_BITS-1:0] fe_base, ae_base, key_base, p_base, addr_a, tgt_base;
    logic [LEN_W-1:0]     fe_len, ae_len, p_len;
    logic [TYPE_W-1:0]    fe_type, ae_type, p_type;
    logic [63:0]          addr_wide, best_wide;

    assign fe_base  = fr_rdata[EW-1 -: ADDR_BITS];
    assign fe_len   = fr_rdata[TYPE_W +: LEN_W];
    assign fe_type  = fr_rdata[TYPE_W-1:0];
    assign ae_base  = ac_rdata[EW-1 -: ADDR_BITS];
    assign ae_len   = ac_rdata[TYPE_W +: LEN_W];
    assign ae_type  = ac_rdata[TYPE_W-1:0];
    assign key_base = key_reg[EW-1 -: ADDR_BITS];
    assign p_base   = pend_reg[EW-1 -: ADDR_BITS];
    assign p_len    = pend_reg[TYPE_W +: LEN_W];
    assign p_type   = pend_reg[TYPE_W-1:0];

    assign addr_wide = 64'(req_reg.addr);
    assign addr_a    = addr_wide[ADDR_BITS-1:0];
    assign best_wide = 64'(best_base_reg);
    assign tgt_base  = (req_reg.mode == MODE_ALLOC) ? best_base_reg : addr_a;

    // Scan control
    logic [SW-1:0] scan_limit;
    logic          scan_issue, scan_done;

    assign scan_limit = (state_reg == ST_FSCAN) ? SW'(free_count_reg) : SW'(ACTIVE_ENTRIES);
    assign scan_issue = scan_idx_reg < scan_limit;
    assign scan_done  = !scan_issue && !chk_vld_reg;

    // Best-fit test on the free entry coming out of the table
    logic [CW-1:0] fb_c, lo_c, hi_c, sm1_c;
    logic          fit, better;

    assign fb_c   = CW'(fe_base);
    assign lo_c   = CW'(req_reg.lo);
    assign hi_c   = CW'(req_reg.hi);
    assign sm1_c  = CW'(req_reg.size - 32'd1);
    assign fit    = (fb_c >= lo_c) && (sm1_c <= hi_c) && (fb_c <= hi_c - sm1_c) &&
                    (fe_len >= req_reg.size) && ((fe_type & req_reg.type_bits) != '0);
    assign better = fit && (!best_vld_reg || fe_len < best_len_reg);

    // Active lookup on the active entry coming out of the table
    logic [AIDX-1:0] chk_aidx;
    logic            a_hit, a_vac;

    assign chk_aidx = chk_idx_reg[AIDX-1:0];
    assign a_hit    = act_valid_reg[chk_aidx] && (ae_base == tgt_base) && !hit_reg;
    assign a_vac    = !act_valid_reg[chk_aidx] && !vac_vld_reg;

    // Apply-stage decisions
    logic            is_alloc, is_shrink, count_full, exact, slot_ok, rel_stop, rel_whole;
    logic            compact_go;
    logic [AIDX-1:0] slot;

    assign is_alloc   = req_reg.mode == MODE_ALLOC;
    assign is_shrink  = req_reg.mode == MODE_SHRINK;
    assign count_full = free_count_reg == FCNT'(FREE_ENTRIES);
    assign exact      = best_len_reg == req_reg.size;
    assign slot_ok    = hit_reg || vac_vld_reg;
    assign slot       = hit_reg ? hit_idx_reg : vac_idx_reg;
    assign rel_stop   = !hit_reg || (is_shrink && req_reg.size >= hit_len_reg) || count_full;
    assign rel_whole  = (req_reg.mode == MODE_RELEASE) || (req_reg.size == '0);
    assign compact_go = free_count_reg != '0;

    // Sort and merge helpers
    logic [FCNT-1:0] j_m1, j_m2, i_p1, m_p1;
    logic            key_move, merge_ok;
    logic [DW-1:0]   gap;
    logic [LEN_W:0]  len_sum;

    assign j_m1     = sort_j_reg - FCNT'(1);
    assign j_m2     = sort_j_reg - FCNT'(2);
    assign i_p1     = sort_i_reg + FCNT'(1);
    assign m_p1     = m_idx_reg + FCNT'(1);
    assign key_move = fe_base > key_base;
    assign gap      = DW'(fe_base) - DW'(p_base);
    assign len_sum  = {1'b0, p_len} + {1'b0, fe_len};
    assign merge_ok = (p_len != '0) && (gap == DW'(p_len)) && (p_type == fe_type) &&
                      (len_sum <= {1'b0, {LEN_W{1'b1}}});

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req.mode == MODE_ADD) begin
                        state_next = ST_ADD;
                    end else if (s_req.mode == MODE_ALLOC) begin
                        state_next = (s_req.size == '0 || free_count_reg == '0) ?
                                     ST_DONE : ST_FSCAN;
                    end else begin
                        state_next = ST_ASCAN;
                    end
                end
            end
            ST_ADD:     state_next = ST_DONE;
            ST_FSCAN: begin
                if (scan_done) begin
                    state_next = best_vld_reg ? ST_ASCAN : ST_DONE;
                end
            end
            ST_ASCAN: begin
                if (scan_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (is_alloc) begin
                    state_next = (slot_ok && exact) ? ST_LAST_RD : ST_DONE;
                end else if (rel_stop || (rel_whole && !is_shrink)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = compact_go ? ST_SORT_RD : ST_DONE;
                end
            end
            ST_LAST_RD: state_next = ST_LAST_MV;
            ST_LAST_MV: state_next = ST_DONE;
            ST_SORT_RD: state_next = ST_SORT_KEY;
            ST_SORT_KEY: state_next = ST_SORT_CMP;
            ST_SORT_CMP: begin
                if (key_move) begin
                    state_next = (j_m1 == '0) ? ST_SORT_PUT : ST_SORT_CMP;
                end else begin
                    state_next = (i_p1 < free_count_reg) ? ST_SORT_RD : ST_MRG_START;
                end
            end
            ST_SORT_PUT: begin
                state_next = (i_p1 < free_count_reg) ? ST_SORT_RD : ST_MRG_START;
            end
            ST_MRG_START: state_next = ST_MRG_LOAD;
            ST_MRG_LOAD:  state_next = ST_MRG_STEP;
            ST_MRG_STEP: begin
                state_next = (m_p1 < free_count_reg) ? ST_MRG_STEP : ST_MRG_TAIL;
            end
            ST_MRG_TAIL: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and table ports
    always_comb begin
        req_next         = req_reg;
        free_count_next  = free_count_reg;
        free_bytes_next  = free_bytes_reg;
        freed_bytes_next = freed_bytes_reg;
        act_valid_next   = act_valid_reg;
        scan_idx_next    = scan_idx_reg;
        chk_vld_next     = chk_vld_reg;
        chk_idx_next     = chk_idx_reg;
        best_vld_next    = best_vld_reg;
        best_idx_next    = best_idx_reg;
        best_base_next   = best_base_reg;
        best_len_next    = best_len_reg;
        best_type_next   = best_type_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_len_next     = hit_len_reg;
        hit_type_next    = hit_type_reg;
        vac_vld_next     = vac_vld_reg;
        vac_idx_next     = vac_idx_reg;
        status_next      = status_reg;
        res_next         = res_reg;
        sort_i_next      = sort_i_reg;
        sort_j_next      = sort_j_reg;
        key_next         = key_reg;
        pend_next        = pend_reg;
        m_idx_next       = m_idx_reg;
        n_next           = n_reg;
        m_rsp_next       = m_rsp_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        fr_we    = 1'b0;
        fr_waddr = free_count_reg[FIDX-1:0];
        fr_wdata = '0;
        fr_raddr = '0;
        ac_we    = 1'b0;
        ac_waddr = slot;
        ac_wdata = '0;
        ac_raddr = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = s_req;
                    status_next   = STAT_OK;
                    res_next      = '0;
                    best_vld_next = 1'b0;
                    hit_next      = 1'b0;
                    vac_vld_next  = 1'b0;
                    scan_idx_next = '0;
                    chk_vld_next  = 1'b0;
                    if (s_req.mode == MODE_ALLOC &&
                        (s_req.size == '0 || free_count_reg == '0)) begin
                        status_next = STAT_NO_FIT;
                    end
                end
            end
            ST_ADD: begin
                if (req_reg.size != '0) begin
                    if (count_full) begin
                        status_next = STAT_FULL;
                    end else begin
                        fr_we           = 1'b1;
                        fr_wdata        = {addr_a, req_reg.size, req_reg.type_bits};
                        free_count_next = free_count_reg + FCNT'(1);
                        free_bytes_next = free_bytes_reg + FADDR_W'(req_reg.size);
                    end
                end
            end
            ST_FSCAN, ST_ASCAN: begin
                fr_raddr = scan_idx_reg[FIDX-1:0];
                ac_raddr = scan_idx_reg[AIDX-1:0];
                chk_vld_next = scan_issue;
                chk_idx_next = scan_idx_reg;
                if (scan_issue) begin
                    scan_idx_next = scan_idx_reg + SW'(1);
                end
                if (chk_vld_reg && state_reg == ST_FSCAN && better) begin
                    best_vld_next  = 1'b1;
                    best_idx_next  = chk_idx_reg[FIDX-1:0];
                    best_base_next = fe_base;
                    best_len_next  = fe_len;
                    best_type_next = fe_type;
                end
                if (chk_vld_reg && state_reg == ST_ASCAN) begin
                    if (a_hit) begin
                        hit_next      = 1'b1;
                        hit_idx_next  = chk_aidx;
                        hit_len_next  = ae_len;
                        hit_type_next = ae_type;
                    end
                    if (a_vac) begin
                        vac_vld_next = 1'b1;
                        vac_idx_next = chk_aidx;
                    end
                end
                if (state_reg == ST_FSCAN && scan_done) begin
                    scan_idx_next = '0;
                    if (!best_vld_reg) begin
                        status_next = STAT_NO_FIT;
                    end
                end
            end
            ST_APPLY: begin
                if (is_alloc) begin
                    if (!slot_ok) begin
                        status_next = STAT_FULL;
                    end else begin
                        ac_we                = 1'b1;
                        ac_waddr             = slot;
                        ac_wdata             = {best_base_reg, req_reg.size, best_type_reg};
                        act_valid_next[slot] = 1'b1;
                        free_bytes_next      = free_bytes_reg - FADDR_W'(req_reg.size);
                        res_next             = best_wide[FADDR_W-1:0];
                        if (!exact) begin
                            // split in place: the tail stays free
                            fr_we    = 1'b1;
                            fr_waddr = best_idx_reg;
                            fr_wdata = {best_base_reg + ADDR_BITS'(req_reg.size),
                                        best_len_reg - req_reg.size, best_type_reg};
                        end
                    end
                end else if (!hit_reg) begin
                    status_next = STAT_NOT_ALLOC;
                end else if (is_shrink && req_reg.size > hit_len_reg) begin
                    status_next = STAT_TOO_LARGE;
                end else if (is_shrink && req_reg.size == hit_len_reg) begin
                    status_next = STAT_OK;
                end else if (count_full) begin
                    status_next = STAT_FULL;
                end else if (rel_whole) begin
                    act_valid_next[hit_idx_reg] = 1'b0;
                    fr_we            = 1'b1;
                    fr_wdata         = {addr_a, hit_len_reg, hit_type_reg};
                    free_count_next  = free_count_reg + FCNT'(1);
                    free_bytes_next  = free_bytes_reg + FADDR_W'(hit_len_reg);
                    freed_bytes_next = freed_bytes_reg + FADDR_W'(hit_len_reg);
                    sort_i_next      = FCNT'(1);
                end else begin
                    ac_we            = 1'b1;
                    ac_waddr         = hit_idx_reg;
                    ac_wdata         = {addr_a, req_reg.size, hit_type_reg};
                    fr_we            = 1'b1;
                    fr_wdata         = {addr_a + ADDR_BITS'(req_reg.size),
                                        hit_len_reg - req_reg.size, hit_type_reg};
                    free_count_next  = free_count_reg + FCNT'(1);
                    free_bytes_next  = free_bytes_reg + FADDR_W'(hit_len_reg - req_reg.size);
                    freed_bytes_next = freed_bytes_reg + FADDR_W'(hit_len_reg - req_reg.size);
                    sort_i_next      = FCNT'(1);
                end
            end
            ST_LAST_RD: begin
                fr_raddr = free_count_reg[FIDX-1:0] - FIDX'(1);
            end
            ST_LAST_MV: begin
                // exact fit: move the last entry into the hole
                fr_we           = 1'b1;
                fr_waddr        = best_idx_reg;
                fr_wdata        = fr_rdata;
                free_count_next = free_count_reg - FCNT'(1);
            end
            ST_SORT_RD: begin
                fr_raddr    = sort_i_reg[FIDX-1:0];
                sort_j_next = sort_i_reg;
            end
            ST_SORT_KEY: begin
                key_next = fr_rdata;
                fr_raddr = j_m1[FIDX-1:0];
            end
            ST_SORT_CMP: begin
                fr_we    = 1'b1;
                fr_waddr = sort_j_reg[FIDX-1:0];
                if (key_move) begin
                    fr_wdata    = fr_rdata;
                    sort_j_next = j_m1;
                    fr_raddr    = j_m2[FIDX-1:0];
                end else begin
                    fr_wdata    = key_reg;
                    sort_i_next = i_p1;
                end
            end
            ST_SORT_PUT: begin
                fr_we       = 1'b1;
                fr_waddr    = sort_j_reg[FIDX-1:0];
                fr_wdata    = key_reg;
                sort_i_next = i_p1;
            end
            ST_MRG_START: begin
                fr_raddr = '0;
                n_next   = '0;
            end
            ST_MRG_LOAD: begin
                pend_next  = fr_rdata;
                fr_raddr   = FIDX'(1);
                m_idx_next = FCNT'(1);
            end
            ST_MRG_STEP: begin
                if (merge_ok) begin
                    pend_next = {p_base, len_sum[LEN_W-1:0], p_type};
                end else begin
                    if (p_len != '0) begin
                        fr_we    = 1'b1;
                        fr_waddr = n_reg[FIDX-1:0];
                        fr_wdata = pend_reg;
                        n_next   = n_reg + FCNT'(1);
                    end
                    pend_next = fr_rdata;
                end
                fr_raddr   = m_p1[FIDX-1:0];
                m_idx_next = m_p1;
            end
            ST_MRG_TAIL: begin
                if (p_len != '0) begin
                    fr_we           = 1'b1;
                    fr_waddr        = n_reg[FIDX-1:0];
                    fr_wdata        = pend_reg;
                    free_count_next = n_reg + FCNT'(1);
                end else begin
                    free_count_next = n_reg;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_rsp_next.status      = status_reg;
                    m_rsp_next.result_addr = res_reg;
                    m_rsp_next.free_total  = free_bytes_reg;
                    m_rsp_next.freed_total = freed_bytes_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            free_count_reg  <= '0;
            free_bytes_reg  <= '0;
            freed_bytes_reg <= '0;
            act_valid_reg   <= '0;
            scan_idx_reg    <= '0;
            chk_vld_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            free_count_reg  <= free_count_next;
            free_bytes_reg  <= free_bytes_next;
            freed_bytes_reg <= freed_bytes_next;
            act_valid_reg   <= act_valid_next;
            scan_idx_reg    <= scan_idx_next;
            chk_vld_reg     <= chk_vld_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        chk_idx_reg   <= chk_idx_next;
        best_vld_reg  <= best_vld_next;
        best_idx_reg  <= best_idx_next;
        best_base_reg <= best_base_next;
        best_len_reg  <= best_len_next;
        best_type_reg <= best_type_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_len_reg   <= hit_len_next;
        hit_type_reg  <= hit_type_next;
        vac_vld_reg   <= vac_vld_next;
        vac_idx_reg   <= vac_idx_next;
        status_reg    <= status_next;
        res_reg       <= res_next;
        sort_i_reg    <= sort_i_next;
        sort_j_reg    <= sort_j_next;
        key_reg       <= key_next;
        pend_reg      <= pend_next;
        m_idx_reg     <= m_idx_next;
        n_reg         <= n_next;
        m_rsp_reg     <= m_rsp_next;
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule

[hw/rtl/bfra_ram.sv]
// Simple dual-port table memory: one write port, one registered read port.
module bfra_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 88,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/bfra_checker.sv]
// Port-level checks for the best-fit region allocator, bound to the top level.
module bfra_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input bfra_pkg::bfra_req_t s_req,
    input logic                m_valid,
    input logic                m_ready,
    input bfra_pkg::bfra_rsp_t m_rsp
);

    import bfra_pkg::*;

    // status is always a defined code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rsp.status == STAT_OK || m_rsp.status == STAT_NO_FIT ||
                     m_rsp.status == STAT_NOT_ALLOC || m_rsp.status == STAT_TOO_LARGE ||
                     m_rsp.status == STAT_FULL))
        else $error("undefined status code");

    // failed requests never return an address
    a_fail_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status != STAT_OK) |-> (m_rsp.result_addr == '0))
        else $error("address returned on failure");

    // one request at a time: no accept right after an accept
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rsp)))
        else $error("result dropped or changed under stall");

    // reset empties the output
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind best_fit_region_allocator bfra_checker u_bfra_checker (.*);

[bench/best_fit_region_allocator_tb.sv]
// Testbench for the best-fit region allocator: predicted responses checked against the DUT.
module best_fit_region_allocator_tb;
    import bfra_pkg::*;

    localparam int NFREE   = 64;
    localparam int NACTIVE = 64;
    localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 200000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    bfra_req_t s_req = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    bfra_rsp_t m_rsp;

    best_fit_region_allocator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_rsp(m_rsp)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shadow heap state used to predict every response.
    logic [47:0] fb [NFREE];
    logic [31:0] fl [NFREE];
    logic [7:0]  ft [NFREE];
    int          fcnt;
    logic [47:0] ab [NACTIVE];
    logic [31:0] al [NACTIVE];
    logic [7:0]  at [NACTIVE];
    bit          av [NACTIVE];
    logic [47:0] free_sum, freed_sum;

    bfra_req_t pending_reqs[$];
    bfra_rsp_t expected_rsps[$];
    int        errors = 0;
    bit        stim_done = 1'b0;
    int        idle_cycles = 0;

    function automatic void enqueue_req(bfra_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic int find_block(logic [47:0] a);
        for (int k = 0; k < NACTIVE; k++)
            if (av[k] && ab[k] == a) return k;
        return -1;
    endfunction

    function automatic void push_region(logic [47:0] b, logic [31:0] l, logic [7:0] t);
        fb[fcnt] = b; fl[fcnt] = l; ft[fcnt] = t;
        fcnt++;
        free_sum = free_sum + 48'(l);
    endfunction

    // Sort by base (stable), merge touching same-type neighbours, drop empties.
    function automatic void sort_and_merge();
        logic [47:0] b;
        logic [31:0] l;
        logic [7:0]  t;
        int j, n;
        for (int i = 1; i < fcnt; i++) begin
            b = fb[i]; l = fl[i]; t = ft[i];
            j = i;
            while (j > 0 && fb[j-1] > b) begin
                fb[j] = fb[j-1]; fl[j] = fl[j-1]; ft[j] = ft[j-1];
                j--;
            end
            fb[j] = b; fl[j] = l; ft[j] = t;
        end
        for (int i = 1; i < fcnt; i++) begin
            if (fl[i-1] != 0 && (fb[i] - fb[i-1]) == 48'(fl[i-1]) && ft[i-1] == ft[i] &&
                (33'(fl[i-1]) + 33'(fl[i])) <= 33'hFFFF_FFFF) begin
                fb[i] = fb[i-1];
                fl[i] = fl[i] + fl[i-1];
                fl[i-1] = 0;
            end
        end
        n = 0;
        for (int i = 0; i < fcnt; i++) begin
            if (fl[i] != 0) begin
                fb[n] = fb[i]; fl[n] = fl[i]; ft[n] = ft[i];
                n++;
            end
        end
        fcnt = n;
    endfunction

    function automatic bfra_status_t best_fit_alloc(bfra_req_t r, output logic [47:0] res);
        int best, slot;
        logic [47:0] b, sm1;
        best = -1;
        slot = -1;
        res = '0;
        if (r.size == 0) return STAT_NO_FIT;
        sm1 = 48'(r.size - 32'd1);
        for (int i = 0; i < fcnt; i++) begin
            b = fb[i];
            if (b >= r.lo && sm1 <= r.hi && b <= r.hi - sm1 && fl[i] >= r.size &&
                (ft[i] & r.type_bits) != 0)
                if (best < 0 || fl[i] < fl[best]) best = i;
        end
        if (best < 0) return STAT_NO_FIT;
        b = fb[best];
        slot = find_block(b);
        if (slot < 0)
            for (int k = 0; k < NACTIVE && slot < 0; k++)
                if (!av[k]) slot = k;
        if (slot < 0) return STAT_FULL;
        ab[slot] = b; al[slot] = r.size; at[slot] = ft[best]; av[slot] = 1'b1;
        if (fl[best] != r.size) begin
            fb[best] = b + 48'(r.size);
            fl[best] = fl[best] - r.size;
        end else begin
            fcnt--;
            fb[best] = fb[fcnt]; fl[best] = fl[fcnt]; ft[best] = ft[fcnt];
        end
        free_sum = free_sum - 48'(r.size);
        res = b;
        return STAT_OK;
    endfunction

    function automatic bfra_rsp_t predict_heap(bfra_req_t r);
        bfra_rsp_t   o;
        logic [47:0] res;
        logic [31:0] len;
        int k;
        o = '0;
        o.status = STAT_OK;
        res = '0;
        case (r.mode)
            MODE_ADD: begin
                if (r.size != 0) begin
                    if (fcnt >= NFREE) o.status = STAT_FULL;
                    else push_region(r.addr, r.size, r.type_bits);
                end
            end
            MODE_ALLOC: o.status = best_fit_alloc(r, res);
            default: begin
                k = find_block(r.addr);
                if (k < 0) o.status = STAT_NOT_ALLOC;
                else if (r.mode == MODE_SHRINK && r.size > al[k]) o.status = STAT_TOO_LARGE;
                else if (r.mode == MODE_SHRINK && r.size == al[k]) o.status = STAT_OK;
                else if (fcnt >= NFREE) o.status = STAT_FULL;
                else if (r.mode == MODE_RELEASE || r.size == 0) begin
                    len = al[k];
                    av[k] = 1'b0;
                    push_region(ab[k], len, at[k]);
                    freed_sum = freed_sum + 48'(len);
                    if (r.mode == MODE_SHRINK) sort_and_merge();
                end else begin
                    len = al[k] - r.size;
                    al[k] = r.size;
                    push_region(r.addr + 48'(r.size), len, at[k]);
                    freed_sum = freed_sum + 48'(len);
                    sort_and_merge();
                end
            end
        endcase
        o.result_addr = res;
        o.free_total  = free_sum;
        o.freed_total = freed_sum;
        return o;
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic bfra_req_t make_req(bfra_mode_t m, logic [31:0] sz, logic [47:0] a,
                                           logic [47:0] lo, logic [47:0] hi, logic [7:0] t);
        bfra_req_t r;
        r.mode = m; r.size = sz; r.addr = a; r.lo = lo; r.hi = hi; r.type_bits = t;
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Accept flag latched at the rising edge so the driver sees a stable value.
    logic s_ready_q = 1'b0;
    always @(posedge aclk) s_ready_q <= s_valid && s_ready;

    // Driver: present the next pending request at the falling edge, hold until accepted; m_ready drops for random gaps.
    int drv_gap = 0;
    int rdy_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready_q) begin
                void'(pending_reqs.pop_front());
                drv_gap = rand_gap();
            end
            if (!(s_valid && !s_ready_q)) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_valid <= 1'b1;
                    s_req   <= pending_reqs[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (rdy_gap > 0) begin
                rdy_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                rdy_gap = rand_gap();
            end
        end
    end

    // Monitor: predict on each accepted request, check each accepted response.
    always @(posedge aclk) begin
        bfra_rsp_t exp_rsp;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_rsps.insert(expected_rsps.size(), predict_heap(s_req));
            end
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response status=%0d", m_rsp.status);
                    errors++;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (m_rsp.status !== exp_rsp.status) begin
                        $error("status expected %0d actual %0d", exp_rsp.status, m_rsp.status);
                        errors++;
                    end
                    if (m_rsp.result_addr !== exp_rsp.result_addr) begin
                        $error("result_addr expected %h actual %h",
                               exp_rsp.result_addr, m_rsp.result_addr);
                        errors++;
                    end
                    if (m_rsp.free_total !== exp_rsp.free_total) begin
                        $error("free_total expected %h actual %h",
                               exp_rsp.free_total, m_rsp.free_total);
                        errors++;
                    end
                    if (m_rsp.freed_total !== exp_rsp.freed_total) begin
                        $error("freed_total expected %h actual %h",
                               exp_rsp.freed_total, m_rsp.freed_total);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Random stimulus mostly builds realistic heaps; addresses stay in a small
    // window so blocks touch and merge, with occasional full-range noise.
    logic [47:0] live_addrs[$];

    task automatic queue_random(int count);
        bfra_req_t r;
        int pick;
        logic [47:0] base;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            base = 48'h1000 + 48'($urandom_range(0, 63) * 16);
            if (pick < 20) begin
                r = make_req(MODE_ADD, 32'($urandom_range(1, 256)), base, '0, '0,
                             8'(1 << $urandom_range(0, 2)));
            end else if (pick < 50) begin
                r = make_req(MODE_ALLOC, 32'($urandom_range(1, 128)), rand48(),
                             48'($urandom_range(0, 2)) << 12, M48 >> $urandom_range(0, 1),
                             8'($urandom_range(1, 7)));
            end else if (pick < 70) begin
                r = make_req(MODE_RELEASE, $urandom(), base, rand48(), rand48(), 8'($urandom()));
            end else if (pick < 92) begin
                r = make_req(MODE_SHRINK, 32'($urandom_range(0, 64)), base, rand48(), rand48(),
                             8'($urandom()));
            end else begin
                r = make_req(bfra_mode_t'($urandom_range(0, 3)), $urandom(), rand48(),
                             rand48(), rand48(), 8'($urandom()));
            end
            enqueue_req(r);
        end
    endtask

    initial begin
        // Directed: empty region, empty request, exact fit, split, ranges.
        enqueue_req(make_req(MODE_ADD, 32'd0, 48'h10, '0, '0, 8'h01));
        enqueue_req(make_req(MODE_ALLOC, 32'd16, '0, '0, M48, 8'hFF));
        enqueue_req(make_req(MODE_ADD, 32'hFFFF_FFFF, M48 - 48'hFFF, '0, '0, 8'h80));
        enqueue_req(make_req(MODE_ADD, 32'd64, 48'h1000, '0, '0, 8'h01));
        enqueue_req(make_req(MODE_ADD, 32'd32, 48'h2000, '0, '0, 8'h01));
        enqueue_req(make_req(MODE_ALLOC, 32'd0, '0, '0, M48, 8'hFF));
        enqueue_req(make_req(MODE_ALLOC, 32'd32, '0, '0, M48, 8'h01));
        enqueue_req(make_req(MODE_ALLOC, 32'd16, '0, 48'h1000, 48'h100F, 8'h01));
        enqueue_req(make_req(MODE_ALLOC, 32'd8, '0, '0, M48, 8'h02));
        enqueue_req(make_req(MODE_ALLOC, 32'hFFFF_FFFF, '0, '0, M48, 8'h80));
        enqueue_req(make_req(MODE_RELEASE, '0, 48'h3333, '0, '0, '0));
        enqueue_req(make_req(MODE_SHRINK, 32'd100, 48'h1000, '0, '0, '0));
        enqueue_req(make_req(MODE_SHRINK, 32'd16, 48'h1000, '0, '0, '0));
        enqueue_req(make_req(MODE_SHRINK, 32'd4, 48'h1000, '0, '0, '0));
        enqueue_req(make_req(MODE_SHRINK, 32'd0, 48'h1000, '0, '0, '0));
        enqueue_req(make_req(MODE_RELEASE, '0, 48'h2000, '0, '0, '0));
        enqueue_req(make_req(MODE_SHRINK, 32'hFFFF_FFFE, M48 - 48'hFFF, M48, M48, 8'hFF));
        enqueue_req(make_req(MODE_RELEASE, 32'hFFFF_FFFF, M48 - 48'hFFF, M48, M48, 8'hFF));
        // Fill the free table past its limit.
        for (int i = 0; i < 70; i++)
            enqueue_req(make_req(MODE_ADD, 32'd1, 48'h8000 + 48'(i * 2), '0, '0, 8'h40));
        enqueue_req(make_req(MODE_RELEASE, '0, 48'h1000, '0, '0, '0));
        // Allocate the small regions until none is left; the last requests find no fit.
        for (int i = 0; i < 66; i++)
            enqueue_req(make_req(MODE_ALLOC, 32'd1, '0, 48'h8000, M48, 8'h40));
        for (int i = 0; i < 64; i++)
            enqueue_req(make_req(MODE_SHRINK, 32'd0, 48'h8000 + 48'(i * 2), '0, '0, '0));
        queue_random(1380);
        fcnt = 0; free_sum = '0; freed_sum = '0;
        for (int k = 0; k < NACTIVE; k++) av[k] = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_reqs.size() != 0 || s_valid) @(posedge aclk);
        while (expected_rsps.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

[best_fit_region_allocator.f]
hw/rtl/bfra_pkg.sv
hw/rtl/bfra_ram.sv
hw/rtl/best_fit_region_allocator.sv
hw/rtl/bfra_checker.sv
bench/best_fit_region_allocator_tb.sv
